FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers; compile with NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define Q8_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define Q8_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define Q8_ASSERT(name, prop)
`define Q8_ASSERT_ALWAYS(name, prop)
`endif
`endif

FILE: src/q8alu_pkg.sv
// ---------------------------------------------------------------------------
// q8alu_pkg
// Types, constants and helpers for the Q24.8 fixed-point ALU.
// ---------------------------------------------------------------------------
package q8alu_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;
  localparam int DIV_NUM_W = DATA_W + FRAC_BITS + 2;
  localparam int DIV_DEN_W = DATA_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_INC      = 4'd6,
    OP_DEC      = 4'd7,
    OP_GT       = 4'd8,
    OP_LT       = 4'd9,
    OP_GE       = 4'd10,
    OP_LE       = 4'd11,
    OP_EQ       = 4'd12,
    OP_NE       = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CLS_ALU = 2'd0,
    CLS_MUL = 2'd1,
    CLS_DIV = 2'd2
  } cls_t;

  typedef struct packed {
    op_t              kind;
    cls_t             cls;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_t           st;
  } res_t;

  function automatic logic [DATA_W-1:0] absval(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  // sign plus magnitude to saturated 32-bit result
  function automatic res_t saturate(input logic neg, input logic [63:0] mag);
    res_t r;
    r.st = ST_OK;
    if (!neg) begin
      if (mag > 64'((64'd1 << (DATA_W - 1)) - 1)) begin
        r.value = {1'b0, {(DATA_W-1){1'b1}}};
        r.st    = ST_OVF;
      end else begin
        r.value = mag[DATA_W-1:0];
      end
    end else begin
      if (mag > (64'd1 << (DATA_W - 1))) begin
        r.value = {1'b1, {(DATA_W-1){1'b0}}};
        r.st    = ST_OVF;
      end else begin
        r.value = ~mag[DATA_W-1:0] + 1'b1;
      end
    end
    return r;
  endfunction

  // 33-bit sum to saturated 32-bit result
  function automatic res_t sat_sum(input logic [DATA_W:0] s);
    res_t r;
    r.st = ST_OK;
    if (s[DATA_W] != s[DATA_W-1]) begin
      r.value = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      r.st    = ST_OVF;
    end else begin
      r.value = s[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: src/q8alu_top.sv
// ---------------------------------------------------------------------------
// q24_8_fixed_point_alu_top
// Q24.8 fixed-point ALU: front end queue, back end execution units.
// ---------------------------------------------------------------------------
//  channel  | handshake     | payload
//  ---------+---------------+------------------------------------
//  command  | start / busy  | kind, operand_a, operand_b
//  result   | done strobe   | result, status
//
// Non-divide ops issue one per cycle unless a divide holds the back end.
// A divide holds the back end while its 42 quotient bits form, one per cycle.
// busy is high in reset and when the 4-entry queue is full; the front keeps
// accepting while the back end works. Results cannot be stalled. Sync reset,
// no sweep.
module q24_8_fixed_point_alu_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [3:0]                          kind,
  input  logic signed [q8alu_pkg::DATA_W-1:0] operand_a,
  input  logic signed [q8alu_pkg::DATA_W-1:0] operand_b,
  output logic                                done,
  output logic signed [q8alu_pkg::DATA_W-1:0] result,
  output logic [1:0]                          status
);

  q8alu_pkg::item_t head;
  logic             head_valid;
  logic             pop;

  q8alu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .kind       (kind),
    .operand_a  (operand_a),
    .operand_b  (operand_b),
    .busy       (busy),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  q8alu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .done       (done),
    .result     (result),
    .status     (status)
  );

endmodule

FILE: src/q8alu_front.sv
// ---------------------------------------------------------------------------
// q8alu_front
// Accepts transactions, classifies them and queues them for the back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module q8alu_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [3:0]                          kind,
  input  logic signed [q8alu_pkg::DATA_W-1:0] operand_a,
  input  logic signed [q8alu_pkg::DATA_W-1:0] operand_b,
  output logic                                busy,
  output q8alu_pkg::item_t                    head,
  output logic                                head_valid,
  input  logic                                pop
);

  q8alu_pkg::item_t                    mem [q8alu_pkg::QDEPTH];
  logic [q8alu_pkg::QPTR_W-1:0]        wptr;
  logic [q8alu_pkg::QPTR_W-1:0]        rptr;
  logic [q8alu_pkg::QCNT_W-1:0]        count;
  logic                                push;
  q8alu_pkg::item_t                    item;

  always_comb begin
    item.kind = q8alu_pkg::op_t'(kind);
    item.a    = operand_a;
    item.b    = operand_b;
    case (item.kind)
      q8alu_pkg::OP_MUL: item.cls = q8alu_pkg::CLS_MUL;
      q8alu_pkg::OP_DIV: item.cls = q8alu_pkg::CLS_DIV;
      default:           item.cls = q8alu_pkg::CLS_ALU;
    endcase
  end

  // held busy through reset so nothing is taken while the queue clears
  assign busy       = rst || (count == q8alu_pkg::QCNT_W'(q8alu_pkg::QDEPTH));
  assign push       = start && !busy;
  assign head_valid = (count != '0);
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + q8alu_pkg::QCNT_W'(push) - q8alu_pkg::QCNT_W'(pop);
    end
  end

  `Q8_ASSERT(a_cnt_bound, count <= q8alu_pkg::QCNT_W'(q8alu_pkg::QDEPTH))
  `Q8_ASSERT(a_pop_nonempty, pop |-> (count != '0))
  `Q8_ASSERT(a_push_cnt, (push && !pop) |=> (count == $past(count) + 1'b1))

endmodule

FILE: src/q8alu_div.sv
// ---------------------------------------------------------------------------
// q8alu_div
// Restoring divider, one quotient bit per cycle, rounded-operand form.
// ---------------------------------------------------------------------------
module q8alu_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [q8alu_pkg::DATA_W-1:0]         a_mag,
  input  logic [q8alu_pkg::DATA_W-1:0]         b_mag,
  output logic                                 busy,
  output logic                                 done,
  output logic [q8alu_pkg::DIV_NUM_W-1:0]      quot
);

  logic [q8alu_pkg::DIV_DEN_W-1:0] rem;
  logic [q8alu_pkg::DIV_DEN_W-1:0] den;
  logic [q8alu_pkg::DIV_CNT_W-1:0] cnt;
  logic [q8alu_pkg::DIV_DEN_W:0]   shifted;
  logic [q8alu_pkg::DIV_DEN_W:0]   trial;
  logic [q8alu_pkg::DIV_NUM_W-1:0] num;

  // (2N + D) / (2D) rounds N/D half away from zero
  assign num = q8alu_pkg::DIV_NUM_W'({a_mag, {q8alu_pkg::FRAC_BITS{1'b0}}, 1'b0})
             + q8alu_pkg::DIV_NUM_W'(b_mag);
  assign shifted = {rem, quot[q8alu_pkg::DIV_NUM_W-1]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
      den  <= {b_mag, 1'b0};
    end else if (busy) begin
      if (!trial[q8alu_pkg::DIV_DEN_W]) begin
        rem  <= trial[q8alu_pkg::DIV_DEN_W-1:0];
        quot <= {quot[q8alu_pkg::DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[q8alu_pkg::DIV_DEN_W-1:0];
        quot <= {quot[q8alu_pkg::DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == q8alu_pkg::DIV_CNT_W'(q8alu_pkg::DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/q8alu_back.sv
// ---------------------------------------------------------------------------
// q8alu_back
// Execution: combinational ops, two-stage multiply, iterative divide.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module q8alu_back (
  input  logic                          clk,
  input  logic                          rst,
  input  q8alu_pkg::item_t              head,
  input  logic                          head_valid,
  output logic                          pop,
  output logic                          done,
  output logic [q8alu_pkg::DATA_W-1:0]  result,
  output logic [1:0]                    status
);

  localparam int DW = q8alu_pkg::DATA_W;
  localparam int FB = q8alu_pkg::FRAC_BITS;

  logic signed [DW-1:0]  sa;
  logic signed [DW-1:0]  sb;
  q8alu_pkg::res_t       alu_res;
  logic                  dz;
  logic signed [DW-1:0]  trunc_tmp;
  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [q8alu_pkg::DIV_NUM_W-1:0] div_q;

  logic                  s1_valid;
  q8alu_pkg::cls_t       s1_cls;
  q8alu_pkg::res_t       s1_res;
  logic signed [63:0]    s1_prod;
  logic                  s1_neg;
  logic                  s1_dz;
  logic                  s1_hold;

  logic [63:0]           pmag;
  logic [63:0]           prnd;
  q8alu_pkg::res_t       fin;

  assign sa = head.a;
  assign sb = head.b;
  assign dz = (head.b == '0);

  always_comb begin
    alu_res.value = '0;
    alu_res.st    = q8alu_pkg::ST_OK;
    trunc_tmp     = sa + (sa[DW-1] ? DW'((1 << FB) - 1) : DW'(0));
    case (head.kind)
      q8alu_pkg::OP_ADD: alu_res = q8alu_pkg::sat_sum({sa[DW-1], sa} + {sb[DW-1], sb});
      q8alu_pkg::OP_SUB: alu_res = q8alu_pkg::sat_sum({sa[DW-1], sa} - {sb[DW-1], sb});
      q8alu_pkg::OP_INC: alu_res = q8alu_pkg::sat_sum({sa[DW-1], sa} + (DW+1)'(1));
      q8alu_pkg::OP_DEC: alu_res = q8alu_pkg::sat_sum({sa[DW-1], sa} - (DW+1)'(1));
      q8alu_pkg::OP_MIN: alu_res.value = (sa > sb) ? sb : sa;
      q8alu_pkg::OP_MAX: alu_res.value = (sa > sb) ? sa : sb;
      q8alu_pkg::OP_GT:  alu_res.value = DW'(sa > sb);
      q8alu_pkg::OP_LT:  alu_res.value = DW'(sa < sb);
      q8alu_pkg::OP_GE:  alu_res.value = DW'(sa >= sb);
      q8alu_pkg::OP_LE:  alu_res.value = DW'(sa <= sb);
      q8alu_pkg::OP_EQ:  alu_res.value = DW'(sa == sb);
      q8alu_pkg::OP_NE:  alu_res.value = DW'(sa != sb);
      q8alu_pkg::OP_FROM_INT: begin
        if ((&sa[DW-1:DW-1-FB]) || !(|sa[DW-1:DW-1-FB])) begin
          alu_res.value = sa <<< FB;
        end else begin
          alu_res.value = sa[DW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
          alu_res.st    = q8alu_pkg::ST_OVF;
        end
      end
      q8alu_pkg::OP_TO_INT: alu_res.value = trunc_tmp >>> FB;
      q8alu_pkg::OP_DIV: begin
        if (dz) begin
          alu_res.st = q8alu_pkg::ST_DZ;
        end
      end
      default: alu_res.value = '0;
    endcase
  end

  assign s1_hold   = s1_valid && (s1_cls == q8alu_pkg::CLS_DIV) && !s1_dz && !div_done;
  assign pop       = head_valid && !s1_hold;
  assign div_start = pop && (head.cls == q8alu_pkg::CLS_DIV) && !dz;

  q8alu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a_mag (q8alu_pkg::absval(head.a)),
    .b_mag (q8alu_pkg::absval(head.b)),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_cls  <= head.cls;
      s1_res  <= alu_res;
      s1_prod <= sa * sb;
      s1_neg  <= sa[DW-1] != sb[DW-1];
      s1_dz   <= dz;
    end
  end

  always_comb begin
    pmag = s1_prod[63] ? (~s1_prod + 1'b1) : s1_prod;
    prnd = (pmag + (64'd1 << (FB - 1))) >> FB;
    case (s1_cls)
      q8alu_pkg::CLS_MUL: fin = q8alu_pkg::saturate(s1_prod[63], prnd);
      q8alu_pkg::CLS_DIV: fin = s1_dz ? s1_res : q8alu_pkg::saturate(s1_neg, 64'(div_q));
      default:            fin = s1_res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= pop || s1_hold;
      done     <= s1_valid && !s1_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && !s1_hold) begin
      result <= fin.value;
      status <= fin.st;
    end
  end

  `Q8_ASSERT(a_div_owner, div_done |-> (s1_valid && s1_cls == q8alu_pkg::CLS_DIV))
  `Q8_ASSERT(a_div_start_idle, div_start |-> !div_busy)
  `Q8_ASSERT(a_dz_zero, (done && status == q8alu_pkg::ST_DZ) |-> (result == '0))

endmodule
